// ===== rtl/core/lvs_pkg.sv =====
// Shared constants, types and codes of the Laplacian variance sharpness unit.
`timescale 1ns / 1ps

package lvs_pkg;

  localparam int PIX_W     = 8;   // pixel width
  localparam int DIM_W     = 11;  // frame size register width
  localparam int COL_W     = 10;  // line store index width
  localparam int LINE_DEPTH = 1024;
  localparam int LAP_W     = 11;  // signed Laplacian width
  localparam int SUM_W     = 32;  // signed Laplacian total
  localparam int SQ_W      = 40;  // total of squares
  localparam int CNT_W     = 21;  // interior position total
  localparam int MAG_W     = 31;  // magnitude of the Laplacian total
  localparam int ACC_W     = 69;  // width of the shared add/subtract unit
  localparam int Q_W       = 28;  // result width
  localparam int POS_W     = 20;  // positions field width
  localparam int FRAC_W    = 8;   // fraction bits of the result
  localparam int ITER_W    = 5;   // iteration counter width
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_DIM        = DIM_W'(1024);
  localparam logic [DIM_W-1:0] WIDTH_RESET    = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET   = DIM_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAP,
    ST_START,
    ST_WAIT
  } lvs_state_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_A,
    PH_MUL_B,
    PH_MUL_C,
    PH_DIV,
    PH_DONE
  } lvs_phase_e;

  typedef struct packed {
    logic                    start;
    logic                    ack;
    logic signed [SUM_W-1:0] lap_sum;
    logic [SQ_W-1:0]         lap_sq;
    logic [CNT_W-1:0]        count;
  } lvs_var_req_t;

  typedef struct packed {
    logic             done;
    logic [Q_W-1:0]   quo;
    logic [POS_W-1:0] positions;
  } lvs_var_rsp_t;

endpackage

// ===== rtl/core/lvs_var_seq.sv =====
// Iterative variance unit: shift-add multiplies and restoring divide on one adder.
`timescale 1ns / 1ps

module lvs_var_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lvs_pkg::lvs_var_req_t req_i,
  output lvs_pkg::lvs_var_rsp_t rsp_o
);

  lvs_pkg::lvs_phase_e phase_q, phase_d;

  logic [lvs_pkg::ACC_W-1:0]  num_q, den_q, mc_q;
  logic [lvs_pkg::MAG_W-1:0]  mp_q, mag_q;
  logic [lvs_pkg::CNT_W-1:0]  n_q;
  logic [lvs_pkg::Q_W-1:0]    quo_q;
  logic [lvs_pkg::ITER_W-1:0] cnt_q;

  logic [lvs_pkg::SUM_W-1:0]  sum_abs;
  logic [lvs_pkg::ACC_W-1:0]  add_a, add_b;
  logic                       add_sub;
  logic [lvs_pkg::ACC_W:0]    add_res;

  always_comb begin
    sum_abs = req_i.lap_sum[lvs_pkg::SUM_W-1] ? lvs_pkg::SUM_W'(-req_i.lap_sum)
                                              : lvs_pkg::SUM_W'(req_i.lap_sum);
  end

  // The one shared adder; carry out on a subtract means no borrow.
  always_comb begin
    add_a   = (phase_q == lvs_pkg::PH_MUL_C) ? den_q : num_q;
    add_b   = (phase_q == lvs_pkg::PH_DIV) ? den_q : mc_q;
    add_sub = (phase_q == lvs_pkg::PH_MUL_B) || (phase_q == lvs_pkg::PH_DIV);
    add_res = {1'b0, add_a} + {1'b0, add_b ^ {lvs_pkg::ACC_W{add_sub}}}
            + {{lvs_pkg::ACC_W{1'b0}}, add_sub};
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      lvs_pkg::PH_IDLE: begin
        if (req_i.start) begin
          phase_d = (req_i.count == '0) ? lvs_pkg::PH_DONE : lvs_pkg::PH_MUL_A;
        end
      end
      lvs_pkg::PH_MUL_A: if (cnt_q == '0) phase_d = lvs_pkg::PH_MUL_B;
      lvs_pkg::PH_MUL_B: if (cnt_q == '0) phase_d = lvs_pkg::PH_MUL_C;
      lvs_pkg::PH_MUL_C: if (cnt_q == '0) phase_d = lvs_pkg::PH_DIV;
      lvs_pkg::PH_DIV:   if (cnt_q == '0) phase_d = lvs_pkg::PH_DONE;
      lvs_pkg::PH_DONE:  if (req_i.ack) phase_d = lvs_pkg::PH_IDLE;
      default:           phase_d = lvs_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lvs_pkg::PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      unique case (phase_q)
        lvs_pkg::PH_IDLE:  cnt_q <= lvs_pkg::ITER_W'(lvs_pkg::CNT_W - 1);
        lvs_pkg::PH_MUL_A: cnt_q <= (cnt_q == '0) ? lvs_pkg::ITER_W'(lvs_pkg::MAG_W - 1)
                                                  : cnt_q - 1'b1;
        lvs_pkg::PH_MUL_B: cnt_q <= (cnt_q == '0) ? lvs_pkg::ITER_W'(lvs_pkg::CNT_W - 1)
                                                  : cnt_q - 1'b1;
        lvs_pkg::PH_MUL_C: cnt_q <= (cnt_q == '0) ? lvs_pkg::ITER_W'(lvs_pkg::Q_W - 1)
                                                  : cnt_q - 1'b1;
        lvs_pkg::PH_DIV:   cnt_q <= (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
        lvs_pkg::PH_DONE:  cnt_q <= cnt_q;
        default:           cnt_q <= '0;
      endcase
    end
  end

  // Datapath: n*sumsq, minus mag*mag, then n*n, then num*256 / (n*n).
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      lvs_pkg::PH_IDLE: begin
        if (req_i.start) begin
          n_q   <= req_i.count;
          mag_q <= sum_abs[lvs_pkg::MAG_W-1:0];
          mc_q  <= lvs_pkg::ACC_W'(req_i.lap_sq);
          mp_q  <= lvs_pkg::MAG_W'(req_i.count);
          num_q <= '0;
          quo_q <= '0;
        end
      end
      lvs_pkg::PH_MUL_A, lvs_pkg::PH_MUL_B: begin
        if (mp_q[0]) num_q <= add_res[lvs_pkg::ACC_W-1:0];
        if (cnt_q == '0) begin
          if (phase_q == lvs_pkg::PH_MUL_A) begin
            mc_q <= lvs_pkg::ACC_W'(mag_q);
            mp_q <= mag_q;
          end else begin
            mc_q  <= lvs_pkg::ACC_W'(n_q);
            mp_q  <= lvs_pkg::MAG_W'(n_q);
            den_q <= '0;
          end
        end else begin
          mc_q <= {mc_q[lvs_pkg::ACC_W-2:0], 1'b0};
          mp_q <= mp_q >> 1;
        end
      end
      lvs_pkg::PH_MUL_C: begin
        if (cnt_q == '0) begin
          // Align for the quotient: scale the numerator by the fraction,
          // put the divisor under the top quotient bit.
          num_q <= num_q << lvs_pkg::FRAC_W;
          den_q <= (mp_q[0] ? add_res[lvs_pkg::ACC_W-1:0] : den_q) << (lvs_pkg::Q_W - 1);
        end else begin
          if (mp_q[0]) den_q <= add_res[lvs_pkg::ACC_W-1:0];
          mc_q <= {mc_q[lvs_pkg::ACC_W-2:0], 1'b0};
          mp_q <= mp_q >> 1;
        end
      end
      lvs_pkg::PH_DIV: begin
        if (add_res[lvs_pkg::ACC_W]) num_q <= add_res[lvs_pkg::ACC_W-1:0];
        quo_q <= {quo_q[lvs_pkg::Q_W-2:0], add_res[lvs_pkg::ACC_W]};
        den_q <= den_q >> 1;
      end
      lvs_pkg::PH_DONE: begin
        quo_q <= quo_q;
      end
      default: begin
        quo_q <= quo_q;
      end
    endcase
  end

  always_comb begin
    rsp_o.done      = (phase_q == lvs_pkg::PH_DONE);
    rsp_o.quo       = quo_q;
    rsp_o.positions = n_q[lvs_pkg::POS_W-1:0];
  end

endmodule

// ===== rtl/core/laplacian_variance_sharpness_unit.sv =====
// Top level of the Laplacian variance sharpness meter.
`timescale 1ns / 1ps

// Sharpness meter for a raster grayscale stream. Pixels arrive one per
// transfer on the input channel, row by row, for a frame of frame_width x
// frame_height (a zero size counts as one, sizes above 1024 saturate). Two
// 1024-entry line stores and four window taps form the 4-neighbour Laplacian
// at each interior position; the block keeps its total, the total of its
// squares and the position count. Each pixel is first accepted, with both
// line stores read at its column; then the Laplacian is formed and squared,
// the totals are updated and the line stores written back, and no new pixel
// is taken until that is done. After the last pixel of a frame one result
// transfer carries the variance (n*sumsq - sum^2)/n^2 in unsigned Q.8,
// truncated, and the count n; it is worked out by one shared 69-bit
// add/subtract unit in 101 steps (21 + 31 + 21 shift-add steps, then 28
// restoring divide steps), during which no pixel is accepted. A frame
// narrower or shorter than 3 gives 0 and 0. A finished result waits
// in an output register, so the next frame may start while it is still
// untaken. Writing either size register restarts the frame; a register
// transfer is taken only while no pixel or end-of-frame work is in progress,
// and it goes ahead of a pixel offered in the same cycle. The line stores
// need no clearing after reset.
module laplacian_variance_sharpness_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lvs_pkg::PIX_W-1:0]      pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lvs_pkg::Q_W-1:0]        sharpness_q8_o,
  output logic [lvs_pkg::POS_W-1:0]      positions_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lvs_pkg::DIM_W-1:0]      cfg_data_i
);

  lvs_pkg::lvs_state_e state_q, state_d;

  logic [lvs_pkg::DIM_W-1:0] width_q, height_q, w_eff, h_eff;
  logic [lvs_pkg::COL_W-1:0] col_q, row_q, rd_col;
  logic signed [lvs_pkg::SUM_W-1:0] lap_sum_q;
  logic [lvs_pkg::SQ_W-1:0]  lap_sq_q;
  logic [lvs_pkg::CNT_W-1:0] pos_cnt_q;
  logic [lvs_pkg::PIX_W-1:0] tap_q [4];   // 0 up, 1 centre, 2 left, 3 down
  logic [lvs_pkg::PIX_W-1:0] px_q, above_q, mid_q;
  logic [lvs_pkg::PIX_W-1:0] upper_mem  [lvs_pkg::LINE_DEPTH];
  logic [lvs_pkg::PIX_W-1:0] middle_mem [lvs_pkg::LINE_DEPTH];

  logic                      out_valid_q;
  logic [lvs_pkg::Q_W-1:0]   sharp_q;
  logic [lvs_pkg::POS_W-1:0] pos_out_q;

  logic accept, cfg_we, cfg_hit, wrap, lap_en, start, load_out, interior, frame_end;
  logic [lvs_pkg::DIM_W-1:0] col_nxt, row_nxt;
  logic [lvs_pkg::LAP_W-1:0] lap_pos;
  logic signed [lvs_pkg::LAP_W-1:0]   lap;
  logic signed [2*lvs_pkg::LAP_W-1:0] lap_prod;

  lvs_pkg::lvs_var_req_t var_req;
  lvs_pkg::lvs_var_rsp_t var_rsp;

  // Effective frame size: zero counts as one, saturate at the line store depth.
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = lvs_pkg::DIM_W'(1);
    else if (width_q > lvs_pkg::MAX_DIM) w_eff = lvs_pkg::MAX_DIM;
    h_eff = height_q;
    if (height_q == '0) h_eff = lvs_pkg::DIM_W'(1);
    else if (height_q > lvs_pkg::MAX_DIM) h_eff = lvs_pkg::MAX_DIM;
  end

  assign accept  = in_valid_i && in_ready_o;
  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign cfg_hit = cfg_we && ((cfg_index_i == lvs_pkg::CFG_FRAME_WIDTH) ||
                              (cfg_index_i == lvs_pkg::CFG_FRAME_HEIGHT));

  // An index past the frame restarts it at the first pixel.
  assign wrap   = ({1'b0, col_q} >= w_eff) || ({1'b0, row_q} >= h_eff);
  assign rd_col = wrap ? '0 : col_q;

  assign col_nxt   = {1'b0, col_q} + lvs_pkg::DIM_W'(1);
  assign row_nxt   = {1'b0, row_q} + lvs_pkg::DIM_W'(1);
  assign frame_end = (col_nxt >= w_eff) && (row_nxt >= h_eff);
  assign interior  = (col_q >= lvs_pkg::COL_W'(2)) && (row_q >= lvs_pkg::COL_W'(2));

  // Laplacian: up + down + left + right - 4*centre; the right neighbour is
  // the middle line entry just read.
  always_comb begin
    lap_pos  = lvs_pkg::LAP_W'(tap_q[0]) + lvs_pkg::LAP_W'(tap_q[3])
             + lvs_pkg::LAP_W'(tap_q[2]) + lvs_pkg::LAP_W'(mid_q);
    lap      = $signed(lap_pos - {1'b0, tap_q[1], 2'b00});
    lap_prod = lap * lap;
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lvs_pkg::ST_IDLE:  if (accept) state_d = lvs_pkg::ST_LAP;
      lvs_pkg::ST_LAP:   state_d = frame_end ? lvs_pkg::ST_START : lvs_pkg::ST_IDLE;
      lvs_pkg::ST_START: state_d = lvs_pkg::ST_WAIT;
      lvs_pkg::ST_WAIT:  if (load_out) state_d = lvs_pkg::ST_IDLE;
      default:           state_d = lvs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs. Hold pixels off while a register transfer is offered.
  always_comb begin
    in_ready_o = (state_q == lvs_pkg::ST_IDLE) && !cfg_valid_i;
    lap_en     = (state_q == lvs_pkg::ST_LAP);
    start      = (state_q == lvs_pkg::ST_START);
    load_out   = (state_q == lvs_pkg::ST_WAIT) && var_rsp.done &&
                 (!out_valid_q || out_ready_i);
  end

  assign cfg_ready_o = (state_q == lvs_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lvs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Size registers, indices and running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= lvs_pkg::WIDTH_RESET;
      height_q  <= lvs_pkg::HEIGHT_RESET;
      col_q     <= '0;
      row_q     <= '0;
      lap_sum_q <= '0;
      lap_sq_q  <= '0;
      pos_cnt_q <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == lvs_pkg::CFG_FRAME_WIDTH) width_q <= cfg_data_i;
      else height_q <= cfg_data_i;
      col_q     <= '0;
      row_q     <= '0;
      lap_sum_q <= '0;
      lap_sq_q  <= '0;
      pos_cnt_q <= '0;
    end else if (accept) begin
      col_q <= rd_col;
      if (wrap) begin
        row_q     <= '0;
        lap_sum_q <= '0;
        lap_sq_q  <= '0;
        pos_cnt_q <= '0;
      end
    end else if (lap_en) begin
      if (interior) begin
        lap_sum_q <= lap_sum_q + lvs_pkg::SUM_W'(lap);
        lap_sq_q  <= lap_sq_q + lvs_pkg::SQ_W'(lap_prod[2*lvs_pkg::LAP_W-2:0]);
        pos_cnt_q <= pos_cnt_q + lvs_pkg::CNT_W'(1);
      end
      if (col_nxt < w_eff) begin
        col_q <= col_nxt[lvs_pkg::COL_W-1:0];
      end else begin
        col_q <= '0;
        row_q <= (row_nxt < h_eff) ? row_nxt[lvs_pkg::COL_W-1:0] : '0;
      end
    end else if (start) begin
      // The variance unit takes the totals at this edge; clear for the next frame.
      lap_sum_q <= '0;
      lap_sq_q  <= '0;
      pos_cnt_q <= '0;
    end
  end

  // Window taps persist across frames.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q[0] <= '0;
      tap_q[1] <= '0;
      tap_q[2] <= '0;
      tap_q[3] <= '0;
    end else if (lap_en) begin
      tap_q[2] <= tap_q[1];
      tap_q[1] <= mid_q;
      tap_q[0] <= above_q;
      tap_q[3] <= px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) px_q <= pixel_i;
  end

  // Line stores: read at the column being accepted, write back in the next cycle.
  always_ff @(posedge clk_i) begin
    if (lap_en) begin
      upper_mem[col_q]  <= mid_q;
      middle_mem[col_q] <= px_q;
    end
    above_q <= upper_mem[rd_col];
    mid_q   <= middle_mem[rd_col];
  end

  always_comb begin
    var_req.start   = start;
    var_req.ack     = load_out;
    var_req.lap_sum = lap_sum_q;
    var_req.lap_sq  = lap_sq_q;
    var_req.count   = pos_cnt_q;
  end

  lvs_var_seq u_var (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (var_req),
    .rsp_o  (var_rsp)
  );

  // Output register: hold the result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sharp_q   <= var_rsp.quo;
      pos_out_q <= var_rsp.positions;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sharpness_q8_o = sharp_q;
  assign positions_o    = pos_out_q;

  // A new result appears only when the variance unit has finished.
  a_out_from_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(var_rsp.done))
    else $error("result raised without a finished variance");

  // No pixel is taken while the variance unit holds a finished result.
  a_ready_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !var_rsp.done)
    else $error("pixel accepted during end-of-frame work");

  // A frame with no interior position reports zero sharpness.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (positions_o == '0)) |-> (sharpness_q8_o == '0))
    else $error("nonzero sharpness for an empty frame");

  // The column being processed lies inside the frame.
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lap_en && !$past(cfg_hit)) |-> ({1'b0, col_q} < w_eff))
    else $error("column index outside the frame");

endmodule
